// ===== hdl/sibd_pkg.sv =====
package sibd_pkg;

    // default width of the signed input value
    localparam int VALUE_BITS_DEF = 32;

    // alphabet limits
    localparam int MAX_DIGITS = 16;
    localparam int MIN_DIGITS = 2;
    localparam int SLOT_COUNT = 16;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_LO    = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_HI    = 8'd126;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIGIT_COUNT = 2'd0,
        CFG_CHARS_LOW   = 2'd1,
        CFG_CHARS_HIGH  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic                done;
        logic [DIGIT_W-1:0]  rem;
    } t_div_stat;

    // character for one digit index of the alphabet
    function automatic logic [CHAR_W-1:0] sibd_char(
        input logic [CFG_W-1:0]   chars_low,
        input logic [CFG_W-1:0]   chars_high,
        input logic [DIGIT_W-1:0] idx
    );
        logic [CFG_W-1:0] word;
        word = idx[DIGIT_W-1] ? chars_high : chars_low;
        return word[{idx[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

// ===== hdl/sibd_if.sv =====
interface sibd_in_if #(
    parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sibd_out_if;
    logic                        valid;
    logic                        ready;
    logic [sibd_pkg::CHAR_W-1:0] character;
    logic                        is_last;

    modport source (output valid, output character, output is_last, input ready);
    modport sink   (input valid, input character, input is_last, output ready);
endinterface

// ===== hdl/sibd_alpha.sv =====
module sibd_alpha (
    input  logic [sibd_pkg::COUNT_W-1:0] i_digit_count,
    input  logic [sibd_pkg::CFG_W-1:0]   i_chars_low,
    input  logic [sibd_pkg::CFG_W-1:0]   i_chars_high,
    output logic                         o_ok
);
    import sibd_pkg::*;

    logic [CHAR_W-1:0] ch [SLOT_COUNT];
    logic              bad;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            ch[i] = sibd_char(i_chars_low, i_chars_high, DIGIT_W'(i));
        end
    end

    // sign characters, non-printable characters and repeats in the used slots
    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (COUNT_W'(i) < i_digit_count) begin
                if (ch[i] == CHAR_MINUS || ch[i] == CHAR_PLUS ||
                    ch[i] < CHAR_LO || ch[i] > CHAR_HI) begin
                    bad = 1'b1;
                end
                for (int j = 0; j < SLOT_COUNT; j++) begin
                    if (j < i && ch[j] == ch[i]) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign o_ok = !bad && (i_digit_count >= COUNT_W'(MIN_DIGITS))
                       && (i_digit_count <= COUNT_W'(MAX_DIGITS));

endmodule

// ===== hdl/sibd_div.sv =====
module sibd_div #(
    parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_BITS-1:0]        i_dividend,
    input  logic [sibd_pkg::COUNT_W-1:0] i_divisor,
    output sibd_pkg::t_div_stat          o_stat,
    output logic [VALUE_BITS-1:0]        o_quot
);
    import sibd_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_q;
    logic [DIGIT_W-1:0]    r_rem;

    logic [COUNT_W-1:0]    trial;
    logic [COUNT_W-1:0]    diff;
    logic                  take;
    logic [VALUE_BITS-1:0] n_q;
    logic [DIGIT_W-1:0]    n_rem;

    // restoring step: dividend bits leave at the top, quotient bits enter below
    always_comb begin
        trial = {r_rem, r_q[VALUE_BITS-1]};
        diff  = trial - i_divisor;
        take  = (trial >= i_divisor);
        n_q   = {r_q[VALUE_BITS-2:0], take};
        n_rem = take ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;
    assign o_quot      = r_q;

endmodule

// ===== hdl/sibd_stack.sv =====
module sibd_stack #(
    parameter int DEPTH = sibd_pkg::VALUE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [sibd_pkg::DIGIT_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [sibd_pkg::DIGIT_W-1:0] o_rdata
);
    import sibd_pkg::*;

    logic [DIGIT_W-1:0] r_mem [DEPTH];
    logic [DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/signed_int_to_base_digits_top.sv =====
// channel  | dir | payload                 | handshake
// i_in     | in  | value (signed)          | valid / ready
// o_out    | out | character, is_last      | valid / ready
// i_cfg_*  | in  | idx, data (64b)         | write enable, no wait
//
// one request runs one full division per digit and emits a minus sign first for
// a negative value; the bit-serial divider produces one quotient bit per cycle
// i_in.ready is high only in idle; an invalid alphabet drops the request at once
// reset is synchronous, active low, and clears state and alphabet registers
// o_out holds its character while o_out.ready is low
module signed_int_to_base_digits_top #(
    parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sibd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sibd_pkg::CFG_W-1:0]     i_cfg_data,
    sibd_in_if.sink                        i_in,
    sibd_out_if.source                     o_out
);
    import sibd_pkg::*;

    localparam int AW   = $clog2(VALUE_BITS);
    localparam int SP_W = $clog2(VALUE_BITS + 1);

    // alphabet registers
    logic [COUNT_W-1:0] r_digit_count;
    logic [CFG_W-1:0]   r_chars_low;
    logic [CFG_W-1:0]   r_chars_high;

    // sequencer
    t_state              r_state, n_state;
    logic                r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic [SP_W-1:0]     r_sp;

    logic                  alpha_ok;
    logic                  div_start;
    t_div_stat             div_stat;
    logic [VALUE_BITS-1:0] div_quot;
    logic                  push;
    logic                  pop;
    logic [SP_W-1:0]       sp_dec;
    logic [DIGIT_W-1:0]    rd_digit;
    logic                  accept;
    logic [VALUE_BITS-1:0] in_value;

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= '0;
            r_chars_low   <= '0;
            r_chars_high  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIGIT_COUNT: r_digit_count <= i_cfg_data[COUNT_W-1:0];
                CFG_CHARS_LOW:   r_chars_low   <= i_cfg_data;
                CFG_CHARS_HIGH:  r_chars_high  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sibd_alpha u_alpha (
        .i_digit_count (r_digit_count),
        .i_chars_low   (r_chars_low),
        .i_chars_high  (r_chars_high),
        .o_ok          (alpha_ok)
    );

    sibd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_digit_count),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // digits come out least significant first, so they are stacked
    sibd_stack #(
        .DEPTH (VALUE_BITS),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_sp[AW-1:0]),
        .i_wdata (div_stat.rem),
        .i_re    (pop),
        .i_raddr (sp_dec[AW-1:0]),
        .o_rdata (rd_digit)
    );

    assign in_value = i_in.value;
    assign sp_dec   = r_sp - 1'b1;
    assign accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state         = r_state;
        i_in.ready      = 1'b0;
        o_out.valid     = 1'b0;
        o_out.is_last   = 1'b0;
        o_out.character = sibd_char(r_chars_low, r_chars_high, rd_digit);
        div_start       = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                // a bad alphabet swallows the request with no output
                if (i_in.valid && alpha_ok) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    push = 1'b1;
                    if (div_quot != '0) begin
                        n_state = S_START;
                    end else if (r_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SIGN: begin
                o_out.valid     = 1'b1;
                o_out.character = CHAR_MINUS;
                if (o_out.ready) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                pop     = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out.valid   = 1'b1;
                o_out.is_last = (r_sp == '0);
                if (o_out.ready) begin
                    n_state = (r_sp == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_sp <= '0;
            end else if (push) begin
                r_sp <= r_sp + 1'b1;
            end else if (pop) begin
                r_sp <= sp_dec;
            end
        end
    end

    // magnitude taken as unsigned, so the most negative value is exact
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= in_value[VALUE_BITS-1];
            r_mag <= in_value[VALUE_BITS-1] ? ('0 - in_value) : in_value;
        end else if (push) begin
            r_mag <= div_quot;
        end
    end

    // no output while a request can be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("output valid while input ready");

    // the last character returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.is_last) |=> i_in.ready)
        else $error("not idle after last character");

    // digit stack never overflows
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(VALUE_BITS))
        else $error("digit stack overflow");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider done out of sequence");

endmodule
